// ===== src/gpc_pkg.sv =====
`default_nettype none
package gpc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int ADDR_W     = 21;
  localparam int BASE_W     = 20;
  localparam int DX_W       = 14;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  typedef enum logic [1:0] {
    MODE_MONO = 2'd0,
    MODE_GRAY = 2'd1,
    MODE_BGRA = 2'd2,
    MODE_NONE = 2'd3
  } pix_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GLYPH_WIDTH   = 3'd0,
    REG_GLYPH_HEIGHT  = 3'd1,
    REG_GLYPH_PITCH   = 3'd2,
    REG_PIXEL_MODE    = 3'd3,
    REG_FG_COLOR      = 3'd4,
    REG_SOURCE_STEP   = 3'd5,
    REG_CANVAS_WIDTH  = 3'd6,
    REG_CANVAS_HEIGHT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [8:0]  glyph_width;
    logic [8:0]  glyph_height;
    logic [10:0] glyph_pitch;
    pix_mode_t   pixel_mode;
    logic [23:0] fg_color;
    logic [15:0] source_step;
    logic [12:0] canvas_width;
    logic [12:0] canvas_height;
  } cfg_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic so;
  } pipe_en_t;

  typedef struct packed {
    logic              valid;
    logic              load;
    logic [11:0]       load_idx;
    logic [7:0]        load_data;
    logic              live;
    logic [BASE_W-1:0] base;
    logic [8:0]        sx;
    logic [11:0]       dest_x;
    logic [11:0]       dest_y;
    logic [31:0]       dst;
  } front_t;

  typedef struct packed {
    logic        valid;
    logic        live;
    logic [31:0] src;
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [31:0] dst;
  } texel_t;

endpackage
`default_nettype wire

// ===== src/glyph_pixel_compositor_unit.sv =====
// Glyph pixel compositor: draws scaled, tinted glyph pixels over a canvas.
// Input channel (in_valid/in_ready): one item per accepted edge. A load item
// writes one byte into the glyph store; a draw item names one destination
// pixel and carries the current canvas pixel.
// Result channel (out_valid/out_ready): exactly one result per item, in
// order. Loads, clipped pixels and transparent texels report no write, with
// dest and pixel fields zero.
// Configuration (cfg_we/cfg_index/cfg_wdata): written only while idle, a
// user rule the block does not enforce. One item per clock unless stalled.
// The glyph store is four byte-wide banks, so a BGRA texel is one read.
// A load followed by a draw of the same byte is ordered by the pipeline.
// Reset clears the valid bits and loads register defaults; the glyph store
// holds garbage until loaded. When the receiver stalls, the output holds and
// bubbles in the pipeline still fill, so up to 6 items are taken before
// in_ready drops.
`default_nettype none
module glyph_pixel_compositor_unit #(
  parameter int GLYPH_BYTES    = 4096,
  parameter int MAX_CANVAS_DIM = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_command,
  input  wire logic [11:0]                     in_byte_index,
  input  wire logic [7:0]                      in_byte_value,
  input  wire logic [7:0]                      in_offset_x,
  input  wire logic [7:0]                      in_offset_y,
  input  wire logic signed [12:0]              in_pen_x,
  input  wire logic signed [12:0]              in_pen_y,
  input  wire logic                            in_bold_pass,
  input  wire logic [31:0]                     in_dst_pixel,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_write_enable,
  output logic [11:0]                          out_dest_x,
  output logic [11:0]                          out_dest_y,
  output logic [31:0]                          out_new_pixel,
  input  wire logic                            cfg_we,
  input  wire logic [gpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gpc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import gpc_pkg::*;

  cfg_t     cfg_r;
  pipe_en_t en;
  front_t   s2;
  texel_t   s4;
  logic     s1_valid;
  logic     s3_valid;
  logic     s5_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.glyph_width   <= 9'd1;
      cfg_r.glyph_height  <= 9'd1;
      cfg_r.glyph_pitch   <= 11'd1;
      cfg_r.pixel_mode    <= MODE_NONE;
      cfg_r.fg_color      <= 24'hFFFFFF;
      cfg_r.source_step   <= 16'd256;
      cfg_r.canvas_width  <= 13'd4096;
      cfg_r.canvas_height <= 13'd4096;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GLYPH_WIDTH:   cfg_r.glyph_width   <= cfg_wdata[8:0];
        REG_GLYPH_HEIGHT:  cfg_r.glyph_height  <= cfg_wdata[8:0];
        REG_GLYPH_PITCH:   cfg_r.glyph_pitch   <= cfg_wdata[10:0];
        REG_PIXEL_MODE:    cfg_r.pixel_mode    <= pix_mode_t'(cfg_wdata[1:0]);
        REG_FG_COLOR:      cfg_r.fg_color      <= cfg_wdata[23:0];
        REG_SOURCE_STEP:   cfg_r.source_step   <= cfg_wdata[15:0];
        REG_CANVAS_WIDTH:  cfg_r.canvas_width  <= cfg_wdata[12:0];
        REG_CANVAS_HEIGHT: cfg_r.canvas_height <= cfg_wdata[12:0];
      endcase
    end
  end

  // a stage moves when it is empty or the one after it moves
  assign en.so = !out_valid || out_ready;
  assign en.s5 = !s5_valid  || en.so;
  assign en.s4 = !s4.valid  || en.s5;
  assign en.s3 = !s3_valid  || en.s4;
  assign en.s2 = !s2.valid  || en.s3;
  assign en.s1 = !s1_valid  || en.s2;

  assign in_ready = en.s1;

  gpc_front #(
    .MAX_CANVAS_DIM (MAX_CANVAS_DIM)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .en            (en),
    .in_valid      (in_valid),
    .in_command    (in_command),
    .in_byte_index (in_byte_index),
    .in_byte_value (in_byte_value),
    .in_offset_x   (in_offset_x),
    .in_offset_y   (in_offset_y),
    .in_pen_x      (in_pen_x),
    .in_pen_y      (in_pen_y),
    .in_bold_pass  (in_bold_pass),
    .in_dst_pixel  (in_dst_pixel),
    .s1_valid      (s1_valid),
    .s2            (s2)
  );

  gpc_fetch #(
    .GLYPH_BYTES (GLYPH_BYTES)
  ) u_fetch (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .en       (en),
    .s2       (s2),
    .s3_valid (s3_valid),
    .s4       (s4)
  );

  gpc_blend u_blend (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (en),
    .s4               (s4),
    .s5_valid         (s5_valid),
    .out_valid        (out_valid),
    .out_write_enable (out_write_enable),
    .out_dest_x       (out_dest_x),
    .out_dest_y       (out_dest_y),
    .out_new_pixel    (out_new_pixel)
  );

endmodule
`default_nettype wire

// ===== src/gpc_ram.sv =====
`default_nettype none
module gpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== src/gpc_front.sv =====
`default_nettype none
module gpc_front #(
  parameter int MAX_CANVAS_DIM = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gpc_pkg::cfg_t       cfg,
  input  wire gpc_pkg::pipe_en_t   en,
  input  wire logic                in_valid,
  input  wire logic                in_command,
  input  wire logic [11:0]         in_byte_index,
  input  wire logic [7:0]          in_byte_value,
  input  wire logic [7:0]          in_offset_x,
  input  wire logic [7:0]          in_offset_y,
  input  wire logic signed [12:0]  in_pen_x,
  input  wire logic signed [12:0]  in_pen_y,
  input  wire logic                in_bold_pass,
  input  wire logic [31:0]         in_dst_pixel,
  output logic                     s1_valid,
  output gpc_pkg::front_t          s2
);
  import gpc_pkg::*;

  localparam int LIM_W = $clog2(MAX_CANVAS_DIM + 1);
  localparam int CMP_W = ((LIM_W > DX_W) ? LIM_W : DX_W) + 1;

  // stage 1
  logic            v1_r;
  logic            load1_r;
  logic [11:0]     idx1_r;
  logic [7:0]      data1_r;
  logic            live1_r;
  logic [23:0]     prodx1_r;
  logic [23:0]     prody1_r;
  logic [DX_W-1:0] dx1_r;
  logic [DX_W-1:0] dy1_r;
  logic [31:0]     dst1_r;

  logic            live1_nxt;
  logic [DX_W-1:0] dx1_nxt;
  logic [DX_W-1:0] dy1_nxt;

  // stage 2
  front_t          s2_r;
  front_t          s2_nxt;

  logic [15:0]     vx;
  logic [15:0]     vy;
  logic [8:0]      sx;
  logic [8:0]      sy;
  logic [CMP_W-1:0] cw;
  logic [CMP_W-1:0] ch;
  logic            in_x;
  logic            in_y;

  assign live1_nxt = (in_command == CMD_DRAW) && (cfg.pixel_mode != MODE_NONE) &&
                     (cfg.glyph_width != 9'd0) && (cfg.glyph_height != 9'd0) &&
                     !(in_bold_pass && (cfg.pixel_mode == MODE_BGRA));
  assign dx1_nxt = {in_pen_x[12], in_pen_x} + {6'd0, in_offset_x} + {13'd0, in_bold_pass};
  assign dy1_nxt = {in_pen_y[12], in_pen_y} + {6'd0, in_offset_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en.s1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      load1_r  <= (in_command == CMD_LOAD);
      idx1_r   <= in_byte_index;
      data1_r  <= in_byte_value;
      live1_r  <= live1_nxt;
      prodx1_r <= 24'(in_offset_x) * 24'(cfg.source_step);
      prody1_r <= 24'(in_offset_y) * 24'(cfg.source_step);
      dx1_r    <= dx1_nxt;
      dy1_r    <= dy1_nxt;
      dst1_r   <= in_dst_pixel;
    end
  end

  // source texel clamp, row base and canvas clip
  assign vx = prodx1_r[23:8];
  assign vy = prody1_r[23:8];
  assign sx = (vx >= {7'd0, cfg.glyph_width})  ? cfg.glyph_width  - 9'd1 : vx[8:0];
  assign sy = (vy >= {7'd0, cfg.glyph_height}) ? cfg.glyph_height - 9'd1 : vy[8:0];

  assign cw = (CMP_W'(cfg.canvas_width) < CMP_W'(MAX_CANVAS_DIM)) ?
              CMP_W'(cfg.canvas_width) : CMP_W'(MAX_CANVAS_DIM);
  assign ch = (CMP_W'(cfg.canvas_height) < CMP_W'(MAX_CANVAS_DIM)) ?
              CMP_W'(cfg.canvas_height) : CMP_W'(MAX_CANVAS_DIM);
  assign in_x = !dx1_r[DX_W-1] && (CMP_W'(dx1_r[DX_W-2:0]) < cw);
  assign in_y = !dy1_r[DX_W-1] && (CMP_W'(dy1_r[DX_W-2:0]) < ch);

  always_comb begin
    s2_nxt           = '0;
    s2_nxt.valid     = v1_r;
    s2_nxt.load      = load1_r;
    s2_nxt.load_idx  = idx1_r;
    s2_nxt.load_data = data1_r;
    s2_nxt.live      = live1_r && in_x && in_y;
    s2_nxt.base      = BASE_W'(sy) * BASE_W'(cfg.glyph_pitch);
    s2_nxt.sx        = sx;
    s2_nxt.dest_x    = dx1_r[11:0];
    s2_nxt.dest_y    = dy1_r[11:0];
    s2_nxt.dst       = dst1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (en.s2) begin
      s2_r <= s2_nxt;
    end
  end

  assign s1_valid = v1_r;
  assign s2       = s2_r;

endmodule
`default_nettype wire

// ===== src/gpc_fetch.sv =====
`default_nettype none
module gpc_fetch #(
  parameter int GLYPH_BYTES = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gpc_pkg::cfg_t     cfg,
  input  wire gpc_pkg::pipe_en_t en,
  input  wire gpc_pkg::front_t   s2,
  output logic                   s3_valid,
  output gpc_pkg::texel_t        s4
);
  import gpc_pkg::*;

  localparam int BANK_DEPTH = GLYPH_BYTES / 4;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  logic [10:0]       off;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] widx;
  logic              wr_ok;
  logic [ADDR_W-1:0] ext   [4];
  logic [3:0]        rd_ok;
  logic [7:0]        rdata [4];

  // stage 3 sidecar
  logic        v3_r;
  logic        live3_r;
  logic [1:0]  lane3_r;
  logic [3:0]  ok3_r;
  logic [2:0]  bit3_r;
  logic [11:0] x3_r;
  logic [11:0] y3_r;
  logic [31:0] dst3_r;

  // stage 4
  texel_t      s4_r;
  texel_t      s4_nxt;
  logic [7:0]  byte_k [4];
  logic [7:0]  cov;

  always_comb begin
    unique case (cfg.pixel_mode)
      MODE_MONO: off = 11'(s2.sx[8:3]);
      MODE_GRAY: off = 11'(s2.sx);
      MODE_BGRA: off = {s2.sx, 2'b00};
      MODE_NONE: off = 11'(s2.sx);
    endcase
  end

  assign addr  = ADDR_W'(s2.base) + ADDR_W'(off);
  assign widx  = ADDR_W'(s2.load_idx);
  assign wr_ok = widx < ADDR_W'(GLYPH_BYTES);

  // four byte-wide banks; consecutive addresses fall in distinct banks
  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic [1:0] lane_off;
    logic       we;
    logic       re;

    assign lane_off = 2'(j) - addr[1:0];
    assign ext[j]   = addr + ADDR_W'(lane_off);
    assign rd_ok[j] = ext[j] < ADDR_W'(GLYPH_BYTES);
    assign we = en.s3 && s2.valid && s2.load && wr_ok && (widx[1:0] == 2'(j));
    assign re = en.s3 && s2.valid && s2.live;

    gpc_ram #(
      .WIDTH (8),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (we),
      .waddr (widx[BANK_AW+1:2]),
      .wdata (s2.load_data),
      .re    (re),
      .raddr (ext[j][BANK_AW+1:2]),
      .rdata (rdata[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en.s3) begin
      v3_r <= s2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      live3_r <= s2.live && !s2.load;
      lane3_r <= addr[1:0];
      ok3_r   <= rd_ok;
      bit3_r  <= s2.sx[2:0];
      x3_r    <= s2.dest_x;
      y3_r    <= s2.dest_y;
      dst3_r  <= s2.dst;
    end
  end

  // texel decode
  for (genvar k = 0; k < 4; k++) begin : g_byte
    logic [1:0] sel;
    assign sel       = lane3_r + 2'(k);
    assign byte_k[k] = ok3_r[sel] ? rdata[sel] : 8'd0;
  end

  always_comb begin
    s4_nxt        = '0;
    s4_nxt.valid  = v3_r;
    s4_nxt.dest_x = x3_r;
    s4_nxt.dest_y = y3_r;
    s4_nxt.dst    = dst3_r;
    cov           = 8'd0;
    unique case (cfg.pixel_mode)
      MODE_MONO: cov = byte_k[0][~bit3_r] ? 8'hFF : 8'h00;
      MODE_GRAY: cov = byte_k[0];
      MODE_BGRA: cov = byte_k[3];
      MODE_NONE: cov = 8'd0;
    endcase
    if (cfg.pixel_mode == MODE_BGRA) begin
      s4_nxt.src = {byte_k[3], byte_k[2], byte_k[1], byte_k[0]};
    end else begin
      s4_nxt.src = {cov, cfg.fg_color};
    end
    s4_nxt.live = live3_r && (cov != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r.valid <= 1'b0;
    end else if (en.s4) begin
      s4_r <= s4_nxt;
    end
  end

  assign s3_valid = v3_r;
  assign s4       = s4_r;

endmodule
`default_nettype wire

// ===== src/gpc_blend.sv =====
`default_nettype none
module gpc_blend (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gpc_pkg::pipe_en_t en,
  input  wire gpc_pkg::texel_t   s4,
  output logic                   s5_valid,
  output logic                   out_valid,
  output logic                   out_write_enable,
  output logic [11:0]            out_dest_x,
  output logic [11:0]            out_dest_y,
  output logic [31:0]            out_new_pixel
);
  import gpc_pkg::*;

  logic        v5_r;
  logic        live5_r;
  logic [11:0] x5_r;
  logic [11:0] y5_r;
  logic [15:0] sum5_r [3];
  logic [15:0] sum5_nxt [3];
  logic [7:0]  q [3];
  logic [7:0]  a;
  logic [7:0]  na;

  logic        out_valid_r;
  logic        out_we_r;
  logic [11:0] out_x_r;
  logic [11:0] out_y_r;
  logic [31:0] out_px_r;

  assign a  = s4.src[31:24];
  assign na = 8'hFF - a;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [16:0] t;
    assign sum5_nxt[c] = 16'(s4.src[8*c +: 8]) * 16'(a) + 16'(s4.dst[8*c +: 8]) * 16'(na);
    // x / 255 for x up to 255*255
    assign t    = 17'(sum5_r[c]) + 17'd1 + 17'(sum5_r[c][15:8]);
    assign q[c] = t[15:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en.s5) begin
      v5_r <= s4.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      live5_r   <= s4.live;
      x5_r      <= s4.dest_x;
      y5_r      <= s4.dest_y;
      sum5_r[0] <= sum5_nxt[0];
      sum5_r[1] <= sum5_nxt[1];
      sum5_r[2] <= sum5_nxt[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en.so) begin
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.so) begin
      out_we_r <= live5_r;
      out_x_r  <= live5_r ? x5_r : 12'd0;
      out_y_r  <= live5_r ? y5_r : 12'd0;
      out_px_r <= live5_r ? {8'hFF, q[2], q[1], q[0]} : 32'd0;
    end
  end

  assign s5_valid         = v5_r;
  assign out_valid        = out_valid_r;
  assign out_write_enable = out_we_r;
  assign out_dest_x       = out_x_r;
  assign out_dest_y       = out_y_r;
  assign out_new_pixel    = out_px_r;

endmodule
`default_nettype wire

// ===== src/gpc_checker.sv =====
`default_nettype none
module gpc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_write_enable,
  input wire logic [11:0] out_dest_x,
  input wire logic [11:0] out_dest_y,
  input wire logic [31:0] out_new_pixel
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_write_enable) &&
      $stable(out_dest_x) && $stable(out_dest_y) && $stable(out_new_pixel))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |->
      out_dest_x == 12'd0 && out_dest_y == 12'd0 && out_new_pixel == 32'd0)
    else $error("non-write result carries data");

  a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_enable |-> out_new_pixel[31:24] == 8'hFF)
    else $error("written pixel not opaque");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind glyph_pixel_compositor_unit gpc_checker u_gpc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_write_enable (out_write_enable),
  .out_dest_x       (out_dest_x),
  .out_dest_y       (out_dest_y),
  .out_new_pixel    (out_new_pixel)
);
`default_nettype wire
